### hdl/worst_fit_block_allocator_unit_defines.svh
// assertion macros used by the allocator top-level rtl
// depends on: nothing; users provide aclk and aresetn in scope
`ifndef WORST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define WFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wfa_pkg.sv
// shared types and constants for the worst-fit allocator
// depends on: nothing
package wfa_pkg;

    localparam int SIZE_W = 13;
    localparam int OFF_W  = 12;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREED      = 2'd2,
        ST_FREE_NULL  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_start;
        logic    walk_step;
        logic    wr_split;
        logic    wr_mark;
        logic    wr_free;
        logic    emit;
        status_t status;
    } wfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_free;
        logic want_zero;
        logic free_ok;
        logic walk_last;
        logic found;
        logic split_ok;
        logic out_busy;
    } wfa_stat_t;

endpackage

### hdl/wfa_ctrl.sv
// sequencer for the allocator: dispatch, chain walk, header updates, result
// depends on: wfa_pkg
module wfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wfa_pkg::wfa_stat_t stat,
    output wfa_pkg::wfa_cmd_t  cmd
);
    import wfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_DECIDE,
        S_SPLIT,
        S_MARK,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.req_free) begin
                    if (stat.free_ok) begin
                        cmd.wr_free = 1'b1;
                        status_next = ST_FREED;
                    end else begin
                        status_next = ST_FREE_NULL;
                    end
                    state_next = S_RESULT;
                end else if (stat.want_zero) begin
                    status_next = ST_ALLOC_FAIL;
                    state_next  = S_RESULT;
                end else begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!stat.found) begin
                    status_next = ST_ALLOC_FAIL;
                    state_next  = S_RESULT;
                end else if (stat.split_ok) begin
                    state_next = S_SPLIT;
                end else begin
                    state_next = S_MARK;
                end
            end
            S_SPLIT: begin
                cmd.wr_split = 1'b1;
                state_next   = S_MARK;
            end
            S_MARK: begin
                cmd.wr_mark = 1'b1;
                status_next = ST_ALLOCATED;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_ALLOC_FAIL;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

### hdl/wfa_datapath.sv
// header store, chain walk arithmetic and result register of the allocator
// depends on: wfa_pkg
module wfa_datapath #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_req_type,
    input  logic [wfa_pkg::SIZE_W-1:0]  s_req_size,
    input  logic [wfa_pkg::OFF_W-1:0]   s_data_offset_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [wfa_pkg::OFF_W-1:0]   m_data_offset_out,
    input  wfa_pkg::wfa_cmd_t           cmd,
    output wfa_pkg::wfa_stat_t          stat
);
    import wfa_pkg::*;

    localparam int ADDR_W = $clog2(POOL_BYTES);
    localparam int CW     = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 2;
    localparam logic [CW-1:0]     POOL_C     = CW'(POOL_BYTES);
    localparam logic [CW-1:0]     HDR_C      = CW'(HEADER_BYTES);
    localparam logic [CW-1:0]     SPLIT_MIN  = CW'(HEADER_BYTES + 1);
    localparam logic [ADDR_W-1:0] RESET_SIZE = ADDR_W'(POOL_BYTES - HEADER_BYTES);

    // header store: data size and free mark, one entry per byte offset
    logic [ADDR_W-1:0] size_mem [POOL_BYTES];
    logic              free_mem [POOL_BYTES];

    logic              type_reg;
    logic [SIZE_W-1:0] want_reg;
    logic [OFF_W-1:0]  doff_reg;
    logic [ADDR_W-1:0] cur_reg, best_reg, best_size_reg;
    logic              found_reg;
    logic              size0_init_reg, free0_init_reg;
    logic [ADDR_W-1:0] rd_size_q;
    logic              rd_free_q, rd_size_init_q, rd_free_init_q;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [OFF_W-1:0]  m_off_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_size;
    logic              cur_free, cand;
    logic [CW-1:0]     nxt, rem, split_pos, hdr_c, best_off;
    logic              split_ok, free_ok, walk_last;
    logic              size_we, free_we, free_wd;
    logic [ADDR_W-1:0] size_wa, free_wa, size_wd;

    // entry 0 reads as the full free pool until it is first written
    assign cur_size = rd_size_init_q ? RESET_SIZE : rd_size_q;
    assign cur_free = rd_free_init_q ? 1'b1 : rd_free_q;

    assign cand = cur_free && (CW'(cur_size) >= CW'(want_reg)) && (cur_size > best_size_reg);
    assign nxt       = CW'(cur_reg) + HDR_C + CW'(cur_size);
    assign walk_last = (nxt >= POOL_C);

    assign rd_en   = cmd.rd_start || (cmd.walk_step && !walk_last);
    assign rd_addr = cmd.rd_start ? '0 : nxt[ADDR_W-1:0];

    assign rem       = CW'(best_size_reg) - CW'(want_reg);
    assign split_pos = CW'(best_reg) + HDR_C + CW'(want_reg);
    assign split_ok  = (rem >= SPLIT_MIN) && (split_pos < POOL_C);
    assign best_off  = CW'(best_reg) + HDR_C;

    assign hdr_c   = CW'(doff_reg) - HDR_C;
    assign free_ok = (CW'(doff_reg) >= HDR_C) && (hdr_c < POOL_C);

    // one write per store per cycle
    always_comb begin
        size_we = 1'b0;
        size_wa = best_reg;
        size_wd = ADDR_W'(want_reg);
        free_we = 1'b0;
        free_wa = best_reg;
        free_wd = 1'b0;
        if (cmd.wr_split) begin
            size_we = 1'b1;
            size_wa = split_pos[ADDR_W-1:0];
            size_wd = ADDR_W'(rem - HDR_C);
            free_we = 1'b1;
            free_wa = split_pos[ADDR_W-1:0];
            free_wd = 1'b1;
        end else if (cmd.wr_mark) begin
            size_we = split_ok;
            free_we = 1'b1;
        end else if (cmd.wr_free) begin
            free_we = 1'b1;
            free_wa = hdr_c[ADDR_W-1:0];
            free_wd = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_wa] <= size_wd;
        end
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        if (rd_en) begin
            rd_size_q      <= size_mem[rd_addr];
            rd_free_q      <= free_mem[rd_addr];
            rd_size_init_q <= size0_init_reg && (rd_addr == '0);
            rd_free_init_q <= free0_init_reg && (rd_addr == '0);
            cur_reg        <= rd_addr;
        end
    end

    // request capture, best-candidate tracking and result capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg <= s_req_type;
            want_reg <= s_req_size;
            doff_reg <= s_data_offset_in;
        end
        if (cmd.load) begin
            best_size_reg <= '0;
        end else if (cmd.walk_step && cand) begin
            best_size_reg <= cur_size;
            best_reg      <= cur_reg;
        end
        if (cmd.emit) begin
            m_status_reg <= cmd.status;
            m_off_reg    <= (cmd.status == ST_ALLOCATED) ? best_off[OFF_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            size0_init_reg <= 1'b1;
            free0_init_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (cmd.walk_step && cand) begin
                found_reg <= 1'b1;
            end
            if (size_we && (size_wa == '0)) begin
                size0_init_reg <= 1'b0;
            end
            if (free_we && (free_wa == '0)) begin
                free0_init_reg <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.req_free  = (type_reg == REQ_FREE);
    assign stat.want_zero = (want_reg == '0);
    assign stat.free_ok   = free_ok;
    assign stat.walk_last = walk_last;
    assign stat.found     = found_reg;
    assign stat.split_ok  = split_ok;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_data_offset_out = m_off_reg;

endmodule

### hdl/worst_fit_block_allocator_unit.sv
// top level of the worst-fit block allocator: controller plus datapath
// depends on: wfa_pkg, wfa_ctrl, wfa_datapath, worst_fit_block_allocator_unit_defines.svh
//
// Requests enter on the s_ channel (s_req_type, s_req_size, s_data_offset_in)
// with valid/ready; one result per request leaves on the m_ channel
// (m_status, m_data_offset_out). s_ready is high only while the block is idle,
// so one request is processed at a time.
// A free request is settled at dispatch and goes straight to the result.
// An allocate request walks the header chain from offset 0 at one block per
// cycle, bounded by the single read port of the header store; a split adds a
// write step before the chosen block is marked, and when no free block fits
// the mark step is skipped. A zero-size allocate fails without a walk.
// The result sits in an output register; the next request is taken while it
// waits, and that request stalls only at its final step until m_ready frees
// the register.
// After reset the pool is one free block at offset 0 covering the whole pool;
// no clearing pass is run, so the block is ready right away.
`include "worst_fit_block_allocator_unit_defines.svh"

module worst_fit_block_allocator_unit #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [wfa_pkg::SIZE_W-1:0]  s_req_size,
    input  logic [wfa_pkg::OFF_W-1:0]   s_data_offset_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [wfa_pkg::OFF_W-1:0]   m_data_offset_out
);
    import wfa_pkg::*;

    wfa_cmd_t  cmd;
    wfa_stat_t stat;

    wfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wfa_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_req_type        (s_req_type),
        .s_req_size        (s_req_size),
        .s_data_offset_in  (s_data_offset_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_data_offset_out (m_data_offset_out),
        .cmd               (cmd),
        .stat              (stat)
    );

    // a transfer always starts work, so the input closes right after
    `WFA_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready,
                     "input open after transfer")
    // a new result never overwrites one that is still waiting
    `WFA_ASSERT_IMP(a_emit_slot_free, cmd.emit, !(m_valid && !m_ready), "result overwritten")
    // only a successful allocate carries an offset
    `WFA_ASSERT_IMP(a_offset_zero, m_valid && (m_status != ST_ALLOCATED),
                    m_data_offset_out == '0, "offset on non-alloc result")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for worst_fit_block_allocator_unit: directed and random
// alloc/free with idle gaps and output stalls, checked against a model of the pool
// depends on: wfa_pkg, worst_fit_block_allocator_unit
module tb_top;
    import wfa_pkg::*;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int DIRECTED_CNT = 23;
    localparam int RANDOM_CNT   = 500;

    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  doff;
        int unsigned       gap;
    } pool_req_t;

    typedef struct {
        status_t          status;
        logic [OFF_W-1:0] offset;
    } pool_reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_req_type = REQ_ALLOC;
    logic [SIZE_W-1:0] s_req_size = '0;
    logic [OFF_W-1:0]  s_data_offset_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [OFF_W-1:0]  m_data_offset_out;

    // model of the header store
    int unsigned chain_size [POOL_BYTES];
    bit          chain_free [POOL_BYTES];

    pool_req_t   pending_reqs[$];
    pool_reply_t awaited_replies[$];
    logic [OFF_W-1:0] held_offsets[$];

    pool_req_t   active_req;
    bit          req_in_flight = 1'b0;
    int unsigned gap_left = 0;
    int unsigned ready_hold = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned mismatches = 0;

    worst_fit_block_allocator_unit #(
        .POOL_BYTES  (POOL_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_req_size       (s_req_size),
        .s_data_offset_in (s_data_offset_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_offset_out(m_data_offset_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // walks the chain like the block does and updates the pool for one request
    function automatic void compute_reply(input pool_req_t r);
        pool_reply_t reply;
        int unsigned walk, nxt, best, best_size, want, hdr, rest;
        bit found;
        reply.status = ST_ALLOC_FAIL;
        reply.offset = '0;
        if (r.kind == REQ_ALLOC) begin
            want = r.size;
            found = 1'b0;
            best = 0;
            best_size = 0;
            walk = 0;
            if (want != 0) begin
                while (walk < POOL_BYTES) begin
                    if (chain_free[walk] && chain_size[walk] >= want
                            && chain_size[walk] > best_size) begin
                        best_size = chain_size[walk];
                        best = walk;
                        found = 1'b1;
                    end
                    nxt = walk + HEADER_BYTES + chain_size[walk];
                    if (nxt >= POOL_BYTES)
                        break;
                    walk = nxt;
                end
            end
            if (found) begin
                rest = best_size - want;
                if (rest >= HEADER_BYTES + 1 && best + HEADER_BYTES + want < POOL_BYTES) begin
                    chain_size[best + HEADER_BYTES + want] = rest - HEADER_BYTES;
                    chain_free[best + HEADER_BYTES + want] = 1'b1;
                    chain_size[best] = want;
                end
                chain_free[best] = 1'b0;
                reply.status = ST_ALLOCATED;
                reply.offset = OFF_W'(best + HEADER_BYTES);
                held_offsets.push_back(reply.offset);
            end
        end else begin
            reply.status = ST_FREE_NULL;
            if (r.doff >= HEADER_BYTES) begin
                hdr = r.doff - HEADER_BYTES;
                if (hdr < POOL_BYTES) begin
                    chain_free[hdr] = 1'b1;
                    reply.status = ST_FREED;
                end
            end
        end
        awaited_replies.push_back(reply);
    endfunction

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        return sender_calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic void queue_req(input logic kind, input int unsigned size,
                                      input int unsigned doff);
        pool_req_t r;
        r.kind = kind;
        r.size = SIZE_W'(size);
        r.doff = OFF_W'(doff);
        r.gap  = draw_gap();
        pending_reqs.push_back(r);
    endfunction

    // driver: one item in flight, valid held until the transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                compute_reply(active_req);
                req_in_flight = 1'b0;
            end
            if (!req_in_flight && pending_reqs.size() > 0) begin
                active_req = pending_reqs.pop_front();
                gap_left = active_req.gap;
                req_in_flight = 1'b1;
            end
            if (req_in_flight && gap_left == 0) begin
                s_valid          <= 1'b1;
                s_req_type       <= active_req.kind;
                s_req_size       <= active_req.size;
                s_data_offset_in <= active_req.doff;
            end else begin
                if (req_in_flight)
                    gap_left--;
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each transfer with the oldest awaited reply
    always @(posedge aclk) begin
        pool_reply_t want_reply;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected result: status %0d offset %0d",
                           m_status, m_data_offset_out);
                    mismatches++;
                end else begin
                    want_reply = awaited_replies.pop_front();
                    if (m_status !== want_reply.status) begin
                        $error("status: expected %0d, got %0d", want_reply.status, m_status);
                        mismatches++;
                    end
                    if (m_data_offset_out !== want_reply.offset) begin
                        $error("data_offset_out: expected %0d, got %0d",
                               want_reply.offset, m_data_offset_out);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    receiver_calm = !receiver_calm;
                ready_hold = receiver_calm ? 0 : $urandom_range(0, 19);
            end
            if (ready_hold == 0) begin
                m_ready <= 1'b1;
            end else begin
                ready_hold--;
                m_ready <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned pick, idx, size, doff;
        for (int i = 0; i < POOL_BYTES; i++) begin
            chain_size[i] = 0;
            chain_free[i] = 1'b0;
        end
        chain_size[0] = POOL_BYTES - HEADER_BYTES;
        chain_free[0] = 1'b1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero size, oversize, null free and free below the first header
        queue_req(REQ_ALLOC, 0, 4095);
        queue_req(REQ_ALLOC, 4096, 0);
        queue_req(REQ_ALLOC, 8191, 0);
        queue_req(REQ_FREE, 8191, 0);
        queue_req(REQ_FREE, 0, 7);
        // remainder too small to split, then pool full
        queue_req(REQ_ALLOC, 4080, 0);
        queue_req(REQ_ALLOC, 1, 0);
        queue_req(REQ_FREE, 0, 8);
        // smallest split: tail block of one byte at the top of the pool
        queue_req(REQ_ALLOC, 4079, 0);
        queue_req(REQ_ALLOC, 1, 0);
        queue_req(REQ_FREE, 0, 4095);
        queue_req(REQ_FREE, 0, 8);
        // two equal free blocks: the earlier one must win
        queue_req(REQ_ALLOC, 100, 0);
        queue_req(REQ_ALLOC, 100, 0);
        queue_req(REQ_ALLOC, 3863, 0);
        queue_req(REQ_FREE, 0, 8);
        queue_req(REQ_FREE, 0, 116);
        queue_req(REQ_ALLOC, 50, 0);
        queue_req(REQ_ALLOC, 100, 0);
        // free off the chain, double free, nothing fits, exact fit
        queue_req(REQ_FREE, 0, 4094);
        queue_req(REQ_FREE, 4096, 4095);
        queue_req(REQ_ALLOC, 43, 0);
        queue_req(REQ_ALLOC, 42, 0);

        for (int n = 0; n < RANDOM_CNT; n++) begin
            // frees need the offsets of earlier allocations, so wait for the driver
            while (pending_reqs.size() != 0 || req_in_flight)
                @(negedge aclk);
            pick = $urandom_range(0, 99);
            if (pick >= 50 && pick < 88 && held_offsets.size() > 0) begin
                idx = $urandom_range(0, held_offsets.size() - 1);
                doff = held_offsets[idx];
                // keep some around so they get freed twice
                if ($urandom_range(0, 99) < 85)
                    held_offsets.delete(idx);
                queue_req(REQ_FREE, $urandom_range(0, 8191), doff);
            end else if (pick >= 88 && pick < 94) begin
                case ($urandom_range(0, 3))
                    0: doff = 0;
                    1: doff = $urandom_range(1, HEADER_BYTES - 1);
                    default: doff = $urandom_range(HEADER_BYTES, 4095);
                endcase
                queue_req(REQ_FREE, $urandom_range(0, 8191), doff);
            end else if (pick >= 94) begin
                size = ($urandom_range(0, 2) == 0) ? 0
                     : $urandom_range(POOL_BYTES - HEADER_BYTES + 1, 8191);
                queue_req(REQ_ALLOC, size, $urandom_range(0, 4095));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    size = $urandom_range(1, 48);
                else if (pick < 90)
                    size = $urandom_range(49, 400);
                else if (pick < 98)
                    size = $urandom_range(401, 2000);
                else
                    size = $urandom_range(2001, POOL_BYTES);
                queue_req(REQ_ALLOC, size, $urandom_range(0, 4095));
            end
        end

        while (pending_reqs.size() != 0 || req_in_flight)
            @(negedge aclk);
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        // long enough for a full walk to surface a stray result
        repeat (600) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
